### hw/rtl/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, types and helpers of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// Bitmap geometry: one bit per 4 KiB frame, stored as wide rows
	localparam int unsigned FRAMES     = 8192;
	localparam int unsigned MAP_BYTES  = FRAMES / 8;
	localparam int unsigned ROW_BITS   = 128;
	localparam int unsigned ROW_BYTES  = ROW_BITS / 8;
	localparam int unsigned ROWS       = FRAMES / ROW_BITS;
	localparam int unsigned ROW_W      = $clog2(ROWS);
	localparam int unsigned BIT_W      = $clog2(ROW_BITS);
	localparam int unsigned BYTE_SEL_W = $clog2(ROW_BYTES);
	// byte index incl. ceil of a 14-bit frame number (up to 2048)
	localparam int unsigned BYTE_IDX_W = 12;

	localparam int unsigned FIELD_W    = 14;
	localparam int unsigned ADDR_W     = 25;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned DATA_W     = 40;

	localparam logic [FIELD_W-1:0] COUNT_MAX   = '1;
	localparam logic [FIELD_W-1:0] HIGH_RESET  = 14'd8192;

	// operation codes
	localparam logic [1:0] OP_ALLOC      = 2'd0;
	localparam logic [1:0] OP_ALLOC_FROM = 2'd1;
	localparam logic [1:0] OP_FREE       = 2'd2;

	// register indexes
	localparam logic [1:0] REG_LOW_FRAME  = 2'd0;
	localparam logic [1:0] REG_HIGH_FRAME = 2'd1;

	typedef struct packed {
		logic [FIELD_W-1:0] low_frame;
		logic [FIELD_W-1:0] high_frame;
	} cfg_t;

	// frames -> bytes, rounded up
	function automatic logic [BYTE_IDX_W-1:0] bytes_up(input logic [FIELD_W-1:0] f);
		logic [BYTE_IDX_W-1:0] b;
		b = {1'b0, f[FIELD_W-1:3]};
		return b + BYTE_IDX_W'(|f[2:0]);
	endfunction

	// index of the lowest set bit
	function automatic logic [BIT_W-1:0] first_set(input logic [ROW_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/bfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Row scanner and read-modify-write sequencer around the bitmap RAM,
// with the allocation counter and the result register.
// ----------------------------------------------------------------------------
module bfa_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bfa_pkg::cfg_t                 cfg,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [1:0]                    s_tuser,
	input  wire logic [bfa_pkg::DATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic                               m_tuser,
	output logic      [bfa_pkg::DATA_W-1:0]    m_tdata
);

	localparam int unsigned ROWS     = bfa_pkg::ROWS;
	localparam int unsigned ROW_W    = bfa_pkg::ROW_W;
	localparam int unsigned BIT_W    = bfa_pkg::BIT_W;
	localparam int unsigned ROW_BITS = bfa_pkg::ROW_BITS;
	localparam int unsigned BI_W     = bfa_pkg::BYTE_IDX_W;
	localparam int unsigned FW       = bfa_pkg::FIELD_W;
	localparam int unsigned AW       = bfa_pkg::ADDR_W;
	localparam int unsigned PS       = bfa_pkg::PAGE_SHIFT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [ROW_W-1:0]     rd_row_q;
	logic [ROW_W-1:0]     last_row_q;
	logic                 issue_q;
	logic [BI_W-1:0]      lo_q;
	logic [BI_W-1:0]      hi_q;
	logic                 chk_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 valid_s1;
	logic                 hit_q;
	logic                 is_free_q;
	logic [ROW_W-1:0]     hit_row_q;
	logic [BIT_W-1:0]     hit_bit_q;
	logic [ROW_BITS-1:0]  wr_data_q;
	logic [FW-1:0]        count_q;
	logic [ROWS-1:0]      valid_q;
	logic                 m_valid_q;
	logic                 m_found_q;
	logic [AW-1:0]        m_addr_q;
	logic [FW-1:0]        m_count_q;

	logic [1:0]           op;
	logic [FW-1:0]        base_frame;
	logic [AW-1:0]        release_address;
	logic [FW-1:0]        first_frame;
	logic [BI_W-1:0]      lo_c;
	logic [BI_W-1:0]      hi_raw;
	logic [BI_W-1:0]      hi_c;
	logic [BI_W-1:0]      hi_m1;
	logic                 rd_en;
	logic                 wr_en;
	logic [ROW_BITS-1:0]  ram_q;
	logic [ROW_BITS-1:0]  row_data;
	logic [ROW_BITS-1:0]  byte_mask;
	logic [ROW_BITS-1:0]  avail;
	logic [BIT_W-1:0]     bit_c;
	logic                 slot_free;
	logic [FW-1:0]        count_next;
	logic                 accept;

	assign op              = s_tuser;
	assign base_frame      = s_tdata[FW-1:0];
	assign release_address = s_tdata[FW+AW-1:FW];
	assign accept          = s_tvalid && s_tready;

	assign first_frame = (op == bfa_pkg::OP_ALLOC_FROM) ? base_frame : cfg.low_frame;
	assign lo_c        = bfa_pkg::bytes_up(first_frame);
	assign hi_raw      = bfa_pkg::bytes_up(cfg.high_frame);
	assign hi_c        = (hi_raw > BI_W'(bfa_pkg::MAP_BYTES)) ? BI_W'(bfa_pkg::MAP_BYTES) : hi_raw;
	assign hi_m1       = hi_c - BI_W'(1);

	assign rd_en     = (state_q == ST_SCAN && issue_q) || state_q == ST_FREE_RD;
	assign slot_free = !m_valid_q || m_tready;
	assign wr_en     = state_q == ST_RESP && slot_free && (hit_q || is_free_q);
	// rows never written read as all free
	assign row_data  = valid_s1 ? ram_q : '0;

	always_comb begin
		logic [BI_W-1:0] gb;
		byte_mask = '0;
		for (int j = 0; j < bfa_pkg::ROW_BYTES; j++) begin
			gb = {2'b00, row_s1, bfa_pkg::BYTE_SEL_W'(j)};
			byte_mask[j*8 +: 8] = {8{(gb >= lo_q) && (gb < hi_q)}};
		end
	end

	assign avail = ~row_data & byte_mask;
	assign bit_c = bfa_pkg::first_set(avail);

	always_comb begin
		count_next = count_q;
		if (hit_q) begin
			if (count_q != bfa_pkg::COUNT_MAX) begin
				count_next = count_q + FW'(1);
			end
		end else if (is_free_q) begin
			if (count_q != '0) begin
				count_next = count_q - FW'(1);
			end
		end
	end

	bfa_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (hit_row_q),
		.wr_data (wr_data_q),
		.rd_en   (rd_en),
		.rd_addr (rd_row_q),
		.rd_data (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_row_q   <= '0;
			last_row_q <= '0;
			issue_q    <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			chk_s1     <= 1'b0;
			row_s1     <= '0;
			valid_s1   <= 1'b0;
			hit_q      <= 1'b0;
			is_free_q  <= 1'b0;
			hit_row_q  <= '0;
			hit_bit_q  <= '0;
			wr_data_q  <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			m_valid_q  <= 1'b0;
			m_found_q  <= 1'b0;
			m_addr_q   <= '0;
			m_count_q  <= '0;
		end else begin
			chk_s1 <= rd_en;
			if (rd_en) begin
				row_s1   <= rd_row_q;
				valid_s1 <= valid_q[rd_row_q];
			end
			// in ST_RESP a taken beat is replaced by the new result below
			if (m_tready && state_q != ST_RESP) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q     <= 1'b0;
						is_free_q <= (op == bfa_pkg::OP_FREE);
						unique case (op) inside
							bfa_pkg::OP_ALLOC, bfa_pkg::OP_ALLOC_FROM: begin
								lo_q       <= lo_c;
								hi_q       <= hi_c;
								rd_row_q   <= lo_c[ROW_W+3:4];
								last_row_q <= hi_m1[ROW_W+3:4];
								if (lo_c < hi_c) begin
									issue_q <= 1'b1;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_RESP;
								end
							end
							bfa_pkg::OP_FREE: begin
								rd_row_q  <= release_address[AW-1:AW-ROW_W];
								hit_row_q <= release_address[AW-1:AW-ROW_W];
								hit_bit_q <= release_address[PS+BIT_W-1:PS];
								state_q   <= ST_FREE_RD;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						rd_row_q <= rd_row_q + ROW_W'(1);
						// stop at the last row or as soon as a free bit shows up
						if (rd_row_q == last_row_q || (chk_s1 && |avail)) begin
							issue_q <= 1'b0;
						end
					end
					if (chk_s1) begin
						if (|avail) begin
							hit_q     <= 1'b1;
							hit_row_q <= row_s1;
							hit_bit_q <= bit_c;
							wr_data_q <= row_data | (ROW_BITS'(1) << bit_c);
							state_q   <= ST_RESP;
						end else if (row_s1 == last_row_q) begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_CHK;
				end
				ST_FREE_CHK: begin
					wr_data_q <= row_data & ~(ROW_BITS'(1) << hit_bit_q);
					state_q   <= ST_RESP;
				end
				ST_RESP: begin
					if (slot_free) begin
						m_valid_q <= 1'b1;
						m_found_q <= hit_q;
						m_addr_q  <= hit_q ? {hit_row_q, hit_bit_q, PS'(0)} : '0;
						m_count_q <= count_next;
						count_q   <= count_next;
						if (hit_q || is_free_q) begin
							valid_q[hit_row_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = {{(bfa_pkg::DATA_W - AW - FW){1'b0}}, m_count_q, m_addr_q};

	a_miss_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_found_q |-> m_addr_q == '0)
		else $error("result without a frame carries a nonzero address");

	a_count_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q == ST_RESP) && m_valid_q)
		else $error("frame count moved outside of a result");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> rd_row_q <= last_row_q)
		else $error("scan read past its last row");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && hit_q |->
			({2'b00, hit_row_q, hit_bit_q[BIT_W-1:3]} >= lo_q) &&
			({2'b00, hit_row_q, hit_bit_q[BIT_W-1:3]} < hi_q))
		else $error("claimed frame lies outside the scan window");

	a_check_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && chk_s1 |-> row_s1 <= last_row_q)
		else $error("scan checked a row past its last row");

endmodule
`default_nettype wire

### hw/rtl/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page frame allocator over a one-bit-per-frame occupancy bitmap.
//
// Channel   Dir  Beat fields (low bit up)
// s_*       in   tuser: op; tdata: base_frame, release_address
// m_*       out  tuser: found; tdata: frame_address, allocated_count
// cfg_*     in   cfg_index (0 low_frame, 1 high_frame), cfg_data
//
// Allocate: scans N bitmap rows (1..64), one 128-bit row per cycle
//   through the single RAM read port; an empty window reads no row.
// Free: one read and one write-back of the frame's row.
// Reset clears per-row valid bits at once; no clearing pass.
// A result waiting on m_tready holds the block before its write-back.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [1:0]                 s_tuser,  // op
	input  wire logic [bfa_pkg::DATA_W-1:0] s_tdata,  // base_frame, release_address
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic                            m_tuser,  // found
	output logic      [bfa_pkg::DATA_W-1:0] m_tdata,  // frame_address, allocated_count
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [bfa_pkg::FIELD_W-1:0] cfg_data
);

	logic [bfa_pkg::FIELD_W-1:0] low_frame_q;
	logic [bfa_pkg::FIELD_W-1:0] high_frame_q;
	bfa_pkg::cfg_t               cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_frame_q  <= '0;
			high_frame_q <= bfa_pkg::HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bfa_pkg::REG_LOW_FRAME:  low_frame_q  <= cfg_data;
				bfa_pkg::REG_HIGH_FRAME: high_frame_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.low_frame  = low_frame_q;
	assign cfg.high_frame = high_frame_q;

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
